[hw/rtl/iprt_pkg.sv]
`default_nettype none
package iprt_pkg;
    localparam int AW = 64;
    localparam int IFW = 8;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_DEL    = 2'd1,
        ACT_DELIF  = 2'd2,
        ACT_LOOKUP = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DUPMISS = 2'd2,
        ST_NOROUTE = 2'd3
    } status_t;

    typedef struct packed {
        logic [AW-1:0]  pfx_hi;
        logic [AW-1:0]  pfx_lo;
        logic [AW-1:0]  msk_hi;
        logic [AW-1:0]  msk_lo;
        logic [AW-1:0]  gw_hi;
        logic [AW-1:0]  gw_lo;
        logic [IFW-1:0] ifc;
    } route_t;

    // Command broadcast to every cell in the chain.
    typedef struct packed {
        action_t        act;
        logic [AW-1:0]  a_hi;
        logic [AW-1:0]  a_lo;
        logic [AW-1:0]  m_hi;
        logic [AW-1:0]  m_lo;
        logic           mgiven;
        logic [AW-1:0]  g_hi;
        logic [AW-1:0]  g_lo;
        logic [IFW-1:0] ifc;
    } cmd_t;

    // Per-cell match flags captured in the compare cycle.
    typedef struct packed {
        logic valid;
        logic dup;
        logic del_hit;
        logic if_hit;
        logic lk_hit;
        logic ins_here;
    } cell_flags_t;

    // Per-cell shift/write controls for the update cycle.
    typedef enum logic [2:0] {
        OP_HOLD  = 3'b001,
        OP_LEFT  = 3'b010,
        OP_RIGHT = 3'b100
    } cell_op_t;

    typedef struct packed {
        cell_op_t src;
        logic     load_new;
        logic     set_valid;
    } cell_ctl_t;
endpackage
`default_nettype wire

[hw/rtl/iprt_cell.sv]
`default_nettype none
module iprt_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  iprt_pkg::cmd_t             cmd,
    input  wire logic                  capture,
    input  iprt_pkg::cell_ctl_t        ctl,
    input  iprt_pkg::route_t           left_route,
    input  wire logic                  left_valid,
    input  iprt_pkg::route_t           right_route,
    input  wire logic                  right_valid,
    output iprt_pkg::route_t           route,
    output wire logic                  valid,
    output iprt_pkg::cell_flags_t      flags
);
    import iprt_pkg::*;

    route_t      route_reg;
    logic        valid_reg;
    cell_flags_t flags_reg, flags_next;
    logic        gw_or_if;
    logic        pfx_eq, msk_eq;

    assign route = route_reg;
    assign valid = valid_reg;
    assign flags = flags_reg;

    always_comb
    begin
        pfx_eq   = route_reg.pfx_hi == cmd.a_hi && route_reg.pfx_lo == cmd.a_lo;
        msk_eq   = route_reg.msk_hi == cmd.m_hi && route_reg.msk_lo == cmd.m_lo;
        gw_or_if = (route_reg.gw_hi == cmd.g_hi && route_reg.gw_lo == cmd.g_lo)
                   || route_reg.ifc == cmd.ifc;
        flags_next.valid    = valid_reg;
        flags_next.dup      = valid_reg && pfx_eq && msk_eq && gw_or_if;
        flags_next.del_hit  = valid_reg && pfx_eq && (!cmd.mgiven || msk_eq) && gw_or_if;
        flags_next.if_hit   = valid_reg && route_reg.ifc == cmd.ifc;
        flags_next.lk_hit   = valid_reg
            && ((cmd.a_hi ^ route_reg.pfx_hi) & route_reg.msk_hi) == '0
            && ((cmd.a_lo ^ route_reg.pfx_lo) & route_reg.msk_lo) == '0;
        flags_next.ins_here = valid_reg
            && ((cmd.m_hi & ~route_reg.msk_hi) | (cmd.m_lo & ~route_reg.msk_lo)) != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            if (capture)
                flags_reg <= flags_next;
            if (ctl.load_new)
                valid_reg <= 1'b1;
            else if (ctl.src == OP_LEFT)
                valid_reg <= left_valid;
            else if (ctl.src == OP_RIGHT)
                valid_reg <= right_valid;
            else if (!ctl.set_valid)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_new)
        begin
            route_reg.pfx_hi <= cmd.a_hi & cmd.m_hi;
            route_reg.pfx_lo <= cmd.a_lo & cmd.m_lo;
            route_reg.msk_hi <= cmd.m_hi;
            route_reg.msk_lo <= cmd.m_lo;
            route_reg.gw_hi  <= cmd.g_hi;
            route_reg.gw_lo  <= cmd.g_lo;
            route_reg.ifc    <= cmd.ifc;
        end
        else if (ctl.src == OP_LEFT)
            route_reg <= left_route;
        else if (ctl.src == OP_RIGHT)
            route_reg <= right_route;
    end
endmodule
`default_nettype wire

[hw/rtl/ipv6_route_table_lpm_core.sv]
`default_nettype none
// IPv6 longest-prefix route table built as a chain of TABLE_ENTRIES cells,
// each holding one route and kept in list order (widest mask first). A
// command beat goes in on s_axis and is compared against every cell at once
// in the first cycle after it is taken; the update cycle then resolves the first
// hit, shifts cells toward their neighbor for an insert or a single delete,
// and loads the result register once the command is finished. Add, delete
// and lookup make one pass each. Delete-interface removes one matching route
// per pass through the chain and repeats until no route matches.
// One result beat per command leaves on m_axis; the next command is taken
// when idle, once the result register is free or drains in the same cycle.
module ipv6_route_table_lpm_core #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output wire logic          s_axis_tready,
    // action[1:0], addr_hi, addr_lo, mask_hi, mask_lo, mask_given,
    // gateway_hi, gateway_lo, iface; zero pad to 400 bits
    input  wire logic [399:0]  s_axis_tdata,
    output wire logic          m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // status[1:0], next_hop_hi, next_hop_lo, out_iface; zero pad to 144 bits
    output wire logic [143:0]  m_axis_tdata
);
    import iprt_pkg::*;
    localparam int N  = TABLE_ENTRIES;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t       state_reg, state_next;
    cmd_t         cmd_reg;
    logic         out_valid_reg;
    logic [143:0] out_data_reg;

    route_t      routes [N];
    logic        valids [N];
    cell_flags_t flags  [N];
    cell_ctl_t   ctls   [N];
    route_t      nulr;

    assign nulr = '0;
    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            iprt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd_reg),
                .capture    (state_reg == S_CMP),
                .ctl        (ctls[g]),
                .left_route ((g == 0) ? nulr : routes[(g == 0) ? 0 : g-1]),
                .left_valid ((g == 0) ? 1'b0 : valids[(g == 0) ? 0 : g-1]),
                .right_route((g == N-1) ? nulr : routes[(g == N-1) ? g : g+1]),
                .right_valid((g == N-1) ? 1'b0 : valids[(g == N-1) ? g : g+1]),
                .route      (routes[g]),
                .valid      (valids[g]),
                .flags      (flags[g])
            );
        end
    endgenerate

    // Prefix ORs locate the first delete and insert hits along the chain.
    logic [N-1:0] dup_v, del_v, if_v, lk_v, ins_v, before_del, before_ins;
    logic         full, any_dup, any_del, any_if, any_lk;
    route_t       lk_route;
    logic         del_go, ins_go;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            dup_v[i] = flags[i].dup;
            del_v[i] = flags[i].del_hit;
            if_v[i]  = flags[i].if_hit;
            lk_v[i]  = flags[i].lk_hit;
            ins_v[i] = flags[i].ins_here;
        end
        full    = flags[N-1].valid;
        any_dup = |dup_v;
        any_if  = |if_v;
        any_lk  = |lk_v;
        del_go  = (cmd_reg.act == ACT_DEL) ? |del_v : any_if;
        ins_go  = (cmd_reg.act == ACT_ADD) && !full && !any_dup;
        any_del = |del_v;
        before_del[0] = 1'b0;
        before_ins[0] = 1'b0;
        for (int i = 1; i < N; i++)
        begin
            before_del[i] = before_del[i-1]
                | ((cmd_reg.act == ACT_DEL) ? del_v[i-1] : if_v[i-1]);
            before_ins[i] = before_ins[i-1] | ins_v[i-1];
        end
        lk_route = '0;
        for (int i = N-1; i >= 0; i--)
            if (lk_v[i])
                lk_route = routes[i];
    end

    // Cell controls: shift right from insert point, left from delete point.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            ctls[i].src       = OP_HOLD;
            ctls[i].load_new  = 1'b0;
            ctls[i].set_valid = 1'b1;
            if (state_reg == S_UPD)
            begin
                if (ins_go)
                begin
                    // insertion point: first ins_here hit, else first empty slot
                    if ((ins_v[i] && !before_ins[i])
                        || (!flags[i].valid && !before_ins[i]
                            && (i == 0 || flags[(i == 0) ? 0 : i-1].valid)))
                        ctls[i].load_new = 1'b1;
                    else if (before_ins[i] || (ins_v[i] && before_ins[i]))
                        ctls[i].src = OP_LEFT;
                end
                else if ((cmd_reg.act == ACT_DEL || cmd_reg.act == ACT_DELIF)
                         && del_go)
                begin
                    if (before_del[i] || ((cmd_reg.act == ACT_DEL) ? del_v[i] : if_v[i]))
                        ctls[i].src = OP_RIGHT;
                end
            end
        end
    end

    logic [1:0]    st;
    logic [AW-1:0] nh_hi, nh_lo;
    logic [7:0]    oif;
    logic          finish;

    always_comb
    begin
        st = ST_OK; nh_hi = '0; nh_lo = '0; oif = '0;
        finish = 1'b1;
        case (cmd_reg.act)
            ACT_ADD:   st = full ? ST_FULL : (any_dup ? ST_DUPMISS : ST_OK);
            ACT_DEL:   st = any_del ? ST_OK : ST_DUPMISS;
            ACT_DELIF: finish = !any_if;
            ACT_LOOKUP:
            begin
                if (!any_lk)
                    st = ST_NOROUTE;
                else
                begin
                    oif = lk_route.ifc;
                    if (lk_route.gw_hi == '0 && lk_route.gw_lo == '0)
                    begin
                        nh_hi = cmd_reg.a_hi;
                        nh_lo = cmd_reg.a_lo;
                    end
                    else
                    begin
                        nh_hi = lk_route.gw_hi;
                        nh_lo = lk_route.gw_lo;
                    end
                end
            end
            default: st = ST_OK;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = S_CMP;
            S_CMP:  state_next = S_UPD;
            S_UPD:  state_next = finish ? S_IDLE : S_CMP;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_UPD && finish)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg.act    <= action_t'(s_axis_tdata[1:0]);
            cmd_reg.a_hi   <= s_axis_tdata[65:2];
            cmd_reg.a_lo   <= s_axis_tdata[129:66];
            cmd_reg.m_hi   <= s_axis_tdata[193:130];
            cmd_reg.m_lo   <= s_axis_tdata[257:194];
            cmd_reg.mgiven <= s_axis_tdata[258];
            cmd_reg.g_hi   <= s_axis_tdata[322:259];
            cmd_reg.g_lo   <= s_axis_tdata[386:323];
            cmd_reg.ifc    <= s_axis_tdata[394:387];
        end
        if (state_reg == S_UPD && finish)
            out_data_reg <= {6'd0, oif, nh_lo, nh_hi, st};
    end

    // The chain stays packed: a valid cell never follows an empty one.
    generate
        for (g = 1; g < N; g++)
        begin : g_chk
            a_packed: assert property (@(posedge clk) disable iff (!rst_n)
                valids[g] |-> valids[g-1])
                else $error("route chain has a gap");
        end
    endgenerate

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("accept while busy");

    a_result_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_UPD))
        else $error("result without update cycle");
endmodule
`default_nettype wire

[tb/tb_ipv6_route_table_lpm_core.sv]
`default_nettype none
module tb_ipv6_route_table_lpm_core;
    timeunit 1ns;
    timeprecision 1ps;

    import iprt_pkg::*;

    localparam int DEPTH = 16;

    // One route request as seen on the command stream.
    typedef struct {
        action_t      act;
        logic [63:0]  a_hi;
        logic [63:0]  a_lo;
        logic [63:0]  m_hi;
        logic [63:0]  m_lo;
        logic         mgiven;
        logic [63:0]  g_hi;
        logic [63:0]  g_lo;
        logic [7:0]   ifc;
    } route_req_t;

    // One answer as seen on the result stream.
    typedef struct {
        status_t      st;
        logic [63:0]  nh_hi;
        logic [63:0]  nh_lo;
        logic [7:0]   oif;
    } route_rsp_t;

    // Mirror of the route list plus the queue of answers still to arrive.
    class route_scoreboard;
        route_t     slots[DEPTH];
        int         used;
        route_rsp_t pending[$];
        int         errors;
        int         checked;
        int         n_hits;

        function void drop_slot(int pos);
            for (int i = pos; i + 1 < used; i++)
                slots[i] = slots[i + 1];
            used--;
        endfunction

        function bool_gw_or_if(int i, route_req_t r);
            return (slots[i].gw_hi == r.g_hi && slots[i].gw_lo == r.g_lo) ||
                   slots[i].ifc == r.ifc;
        endfunction

        // Apply one accepted command and queue the answer it must produce.
        function void note_command(route_req_t r);
            route_rsp_t rsp;
            int pos;
            bit dup;
            rsp = '{ST_OK, 64'h0, 64'h0, 8'h0};
            pos = -1;
            dup = 0;
            case (r.act)
                ACT_ADD:
                begin
                    if (used >= DEPTH)
                        rsp.st = ST_FULL;
                    else
                    begin
                        for (int i = 0; i < used; i++)
                            if (!dup && slots[i].pfx_hi == r.a_hi && slots[i].pfx_lo == r.a_lo &&
                                slots[i].msk_hi == r.m_hi && slots[i].msk_lo == r.m_lo &&
                                bool_gw_or_if(i, r))
                                dup = 1;
                        if (dup)
                            rsp.st = ST_DUPMISS;
                        else
                        begin
                            pos = used;
                            for (int i = used - 1; i >= 0; i--)
                                if (((r.m_hi & ~slots[i].msk_hi) | (r.m_lo & ~slots[i].msk_lo)) != 0)
                                    pos = i;
                            for (int i = used; i > pos; i--)
                                slots[i] = slots[i - 1];
                            slots[pos] = '{r.a_hi & r.m_hi, r.a_lo & r.m_lo, r.m_hi, r.m_lo,
                                           r.g_hi, r.g_lo, r.ifc};
                            used++;
                        end
                    end
                end
                ACT_DEL:
                begin
                    for (int i = used - 1; i >= 0; i--)
                        if (slots[i].pfx_hi == r.a_hi && slots[i].pfx_lo == r.a_lo &&
                            (!r.mgiven || (slots[i].msk_hi == r.m_hi &&
                                           slots[i].msk_lo == r.m_lo)) &&
                            bool_gw_or_if(i, r))
                            pos = i;
                    if (pos < 0)
                        rsp.st = ST_DUPMISS;
                    else
                        drop_slot(pos);
                end
                ACT_DELIF:
                begin
                    pos = 0;
                    while (pos < used)
                        if (slots[pos].ifc == r.ifc)
                            drop_slot(pos);
                        else
                            pos++;
                end
                default:
                begin
                    for (int i = used - 1; i >= 0; i--)
                        if ((r.a_hi & slots[i].msk_hi) == (slots[i].pfx_hi & slots[i].msk_hi) &&
                            (r.a_lo & slots[i].msk_lo) == (slots[i].pfx_lo & slots[i].msk_lo))
                            pos = i;
                    if (pos < 0)
                        rsp.st = ST_NOROUTE;
                    else
                    begin
                        n_hits++;
                        rsp.oif = slots[pos].ifc;
                        if (slots[pos].gw_hi == 0 && slots[pos].gw_lo == 0)
                        begin
                            rsp.nh_hi = r.a_hi;
                            rsp.nh_lo = r.a_lo;
                        end
                        else
                        begin
                            rsp.nh_hi = slots[pos].gw_hi;
                            rsp.nh_lo = slots[pos].gw_lo;
                        end
                    end
                end
            endcase
            pending.push_back(rsp);
        endfunction

        // Compare one result beat with the oldest pending answer.
        function void check_answer(route_rsp_t got);
            route_rsp_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat: status %0d", got.st);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.st !== want.st)
            begin
                $error("status: expected %0d, got %0d", want.st, got.st);
                errors++;
            end
            if (got.nh_hi !== want.nh_hi)
            begin
                $error("next_hop_hi: expected %h, got %h", want.nh_hi, got.nh_hi);
                errors++;
            end
            if (got.nh_lo !== want.nh_lo)
            begin
                $error("next_hop_lo: expected %h, got %h", want.nh_lo, got.nh_lo);
                errors++;
            end
            if (got.oif !== want.oif)
            begin
                $error("out_iface: expected %h, got %h", want.oif, got.oif);
                errors++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    // action, addr_hi, addr_lo, mask_hi, mask_lo, mask_given, gateway_hi,
    // gateway_lo, iface (lowest bit up), zero pad to 400 bits
    logic [399:0]  s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    // status, next_hop_hi, next_hop_lo, out_iface (lowest bit up), zero pad
    logic [143:0]  m_axis_tdata;

    route_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int n_beats;

    // Small pools of prefixes, gateways and interfaces so that adds, deletes
    // and lookups keep hitting the same routes.
    logic [63:0] pool_addr[8];
    logic [63:0] pool_gw[4];
    logic [7:0]  pool_if[4];

    ipv6_route_table_lpm_core #(.TABLE_ENTRIES(DEPTH)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver side: stall at random at each falling edge, check at the rising edge.
    always @(negedge clk)
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        route_rsp_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.st    = status_t'(m_axis_tdata[1:0]);
            got.nh_hi = m_axis_tdata[65:2];
            got.nh_lo = m_axis_tdata[129:66];
            got.oif   = m_axis_tdata[137:130];
            sb.check_answer(got);
        end
    end

    // Present one command beat; hold it until the block takes it.
    task automatic send_cmd(route_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata <= {5'h0, r.ifc, r.g_lo, r.g_hi, r.mgiven, r.m_lo, r.m_hi,
                         r.a_lo, r.a_hi, r.act};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_command(r);
        n_beats++;
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Contiguous mask of the given prefix length, as one 128-bit value.
    function automatic logic [127:0] plen_mask(int plen);
        logic [127:0] m;
        m = '0;
        for (int i = 0; i < plen; i++)
            m[127 - i] = 1'b1;
        return m;
    endfunction

    function automatic route_req_t mk(action_t act, logic [63:0] ah, logic [63:0] al,
                                      logic [127:0] m, logic mg, logic [63:0] gh,
                                      logic [63:0] gl, logic [7:0] ifc);
        route_req_t r;
        r = '{act, ah, al, m[127:64], m[63:0], mg, gh, gl, ifc};
        return r;
    endfunction

    // Mostly well-formed commands drawn from the pools, some pure noise.
    function automatic route_req_t rand_cmd();
        route_req_t r;
        logic [127:0] m;
        int sel;
        sel = $urandom_range(99);
        if ($urandom_range(3) == 0)
            m = {rand64(), rand64()};
        else
            m = plen_mask($urandom_range(128));
        r = mk(action_t'($urandom_range(3)), pool_addr[$urandom_range(7)],
               pool_addr[$urandom_range(7)], m, $urandom_range(1),
               $urandom_range(3) == 0 ? 64'h0 : pool_gw[$urandom_range(3)],
               pool_gw[$urandom_range(3)], pool_if[$urandom_range(3)]);
        if (sel < 40)
            r.act = ACT_ADD;
        else if (sel < 55)
            r.act = ACT_DEL;
        else if (sel < 60)
            r.act = ACT_DELIF;
        else
            r.act = ACT_LOOKUP;
        // Delete with the stored form of the prefix so that it can hit.
        if (r.act == ACT_DEL && $urandom_range(1))
        begin
            r.a_hi &= r.m_hi;
            r.a_lo &= r.m_lo;
        end
        // Noise: address, gateway and interface get fully random bits.
        if (sel % 10 == 0)
        begin
            r.a_hi = rand64();
            r.a_lo = rand64();
            r.g_hi = rand64();
            r.g_lo = rand64();
            r.ifc  = $urandom_range(255);
        end
        return r;
    endfunction

    initial
    begin
        logic [127:0] ones;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        n_beats = 0;
        ones = '1;
        for (int i = 0; i < 8; i++)
            pool_addr[i] = rand64();
        for (int i = 0; i < 4; i++)
        begin
            pool_gw[i] = rand64();
            pool_if[i] = $urandom_range(255);
        end
        pool_if[0] = 8'hff;
        pool_if[1] = 8'h00;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, extremes, duplicates, misses, full table.
        send_cmd(mk(ACT_LOOKUP, '1, '1, 0, 0, 0, 0, 0));
        send_cmd(mk(ACT_DEL, '1, '1, ones, 1, '1, '1, 8'hff));
        send_cmd(mk(ACT_ADD, '1, '1, ones, 0, '1, '1, 8'hff));
        send_cmd(mk(ACT_ADD, '1, '1, ones, 0, '1, '1, 8'h01));
        send_cmd(mk(ACT_ADD, '1, '1, ones, 0, 0, 0, 8'hff));
        send_cmd(mk(ACT_ADD, 64'h2001, 64'h0, plen_mask(0), 0, 0, 0, 8'h00));
        send_cmd(mk(ACT_ADD, '1, 64'h0, plen_mask(64), 0, 0, 0, 8'h07));
        send_cmd(mk(ACT_LOOKUP, '1, '1, 0, 0, 0, 0, 0));
        send_cmd(mk(ACT_LOOKUP, '1, 64'h1234, 0, 0, 0, 0, 0));
        send_cmd(mk(ACT_LOOKUP, 64'h5, 64'h6, 0, 0, 0, 0, 0));
        send_cmd(mk(ACT_DEL, '1, '1, 0, 0, 0, 0, 8'hff));
        send_cmd(mk(ACT_DEL, 64'h0, 64'h0, plen_mask(0), 1, 64'h9, 64'h9, 8'h00));
        send_cmd(mk(ACT_DELIF, 0, 0, 0, 0, 0, 0, 8'h07));
        send_cmd(mk(ACT_DELIF, 0, 0, 0, 0, 0, 0, 8'h33));
        for (int i = 0; i < DEPTH + 1; i++)
            send_cmd(mk(ACT_ADD, rand64(), rand64(), plen_mask(i * 8), 0, rand64(), rand64(),
                        8'h40 + i[7:0]));
        send_cmd(mk(ACT_LOOKUP, rand64(), rand64(), 0, 0, 0, 0, 0));
        send_cmd(mk(ACT_DELIF, 0, 0, 0, 0, 0, 0, 8'h41));

        // Random phases: receiver idles mostly, then sender, then neither.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 75 : 0;
            recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 32 : 0;
            for (int k = 0; k < 250; k++)
            begin
                // Clear out now and then so the table does not stay full.
                if ($urandom_range(59) == 0)
                    for (int j = 0; j < 4; j++)
                        send_cmd(mk(ACT_DELIF, 0, 0, 0, 0, 0, 0, pool_if[j]));
                send_cmd(rand_cmd());
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Ran %0d route commands, checked %0d answers, %0d lookup hits.",
                 n_beats, sb.checked, sb.n_hits);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
hw/rtl/iprt_pkg.sv
hw/rtl/iprt_cell.sv
hw/rtl/ipv6_route_table_lpm_core.sv
tb/tb_ipv6_route_table_lpm_core.sv
